FILE: hdl/i2c_mts_pkg.sv
// Shared types and constants for the I2C master transfer sequencer.
`default_nettype none
package i2c_mts_pkg;

    localparam int REG_BYTES_MAX_DEF = 4;
    localparam int PAY_BYTES_MAX_DEF = 32;

    localparam int CMD_W    = 2;
    localparam int IDX_W    = 5;
    localparam int BYTE_W   = 8;
    localparam int TGT_W    = 7;
    localparam int RLEN_W   = 3;
    localparam int PLEN_W   = 6;
    localparam int ACT_W    = 3;
    localparam int STATUS_W = 2;

    localparam logic READ_BIT = 1'b1;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD_REG  = 2'd0,
        CMD_LOAD_DATA = 2'd1,
        CMD_START     = 2'd2,
        CMD_EVENT     = 2'd3
    } t_cmd;

    typedef enum logic [ACT_W-1:0] {
        ACT_NONE       = 3'd0,
        ACT_ADDR       = 3'd1,
        ACT_SEND       = 3'd2,
        ACT_RESTART_RD = 3'd3,
        ACT_RECV       = 3'd4,
        ACT_STOP_ACK   = 3'd5,
        ACT_STOP_NACK  = 3'd6
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_IDLE   = 2'd0,
        ST_BUSY   = 2'd1,
        ST_FAILED = 2'd2
    } t_status;

endpackage
`default_nettype wire

FILE: hdl/i2c_master_transfer_sequencer.sv
// Top level: I2C master transfer sequencer deciding bus engine commands.
`default_nettype none
// Takes one item per clock and returns exactly one result item for each: the
// item is captured in an input register, decided by a single pass of logic
// against the held transfer state, and parked in a result register. A stalled
// result register holds the input register, so throughput is one item per
// cycle whenever o_out_valid is taken. Register-address bytes (up to
// REGISTER_BYTES_MAX) and payload bytes (up to PAYLOAD_BYTES_MAX) are held in
// flops; a byte read before it was ever loaded returns an undefined value.
// Received bytes are written back into the payload buffer.
module i2c_master_transfer_sequencer #(
    parameter int REGISTER_BYTES_MAX = i2c_mts_pkg::REG_BYTES_MAX_DEF,
    parameter int PAYLOAD_BYTES_MAX  = i2c_mts_pkg::PAY_BYTES_MAX_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output      logic                               o_in_ready,
    input  wire logic [i2c_mts_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic [i2c_mts_pkg::IDX_W-1:0]      i_byte_index,
    input  wire logic [i2c_mts_pkg::BYTE_W-1:0]     i_byte_value,
    input  wire logic [i2c_mts_pkg::TGT_W-1:0]      i_target_address,
    input  wire logic [i2c_mts_pkg::RLEN_W-1:0]     i_register_length,
    input  wire logic [i2c_mts_pkg::PLEN_W-1:0]     i_payload_length,
    input  wire logic                               i_read_direction,
    input  wire logic                               i_arbitration_lost,
    input  wire logic                               i_bus_fault,
    input  wire logic                               i_got_nack,
    input  wire logic                               i_write_ready,
    input  wire logic                               i_read_ready,
    output      logic                               o_out_valid,
    input  wire logic                               i_out_ready,
    output      logic [i2c_mts_pkg::ACT_W-1:0]      o_action,
    output      logic [i2c_mts_pkg::BYTE_W-1:0]     o_address_byte,
    output      logic                               o_quick_command,
    output      logic [i2c_mts_pkg::BYTE_W-1:0]     o_send_byte,
    output      logic                               o_stored_valid,
    output      logic [i2c_mts_pkg::IDX_W-1:0]      o_stored_index,
    output      logic [i2c_mts_pkg::BYTE_W-1:0]     o_stored_byte,
    output      logic [i2c_mts_pkg::STATUS_W-1:0]   o_transfer_state,
    output      logic                               o_completed
);
    import i2c_mts_pkg::*;

    localparam int LEN_MAX = (PAYLOAD_BYTES_MAX > REGISTER_BYTES_MAX) ?
                             PAYLOAD_BYTES_MAX : REGISTER_BYTES_MAX;
    localparam int POS_W   = $clog2(LEN_MAX + 1);
    localparam int RIDX_W  = (REGISTER_BYTES_MAX > 1) ? $clog2(REGISTER_BYTES_MAX) : 1;
    localparam int PIDX_W  = (PAYLOAD_BYTES_MAX > 1) ? $clog2(PAYLOAD_BYTES_MAX) : 1;

    // input register
    logic                r_in_valid;
    t_cmd                r_cmd;
    logic [IDX_W-1:0]    r_byte_index;
    logic [BYTE_W-1:0]   r_byte_value;
    logic [TGT_W-1:0]    r_target_address;
    logic [RLEN_W-1:0]   r_register_length;
    logic [PLEN_W-1:0]   r_payload_length;
    logic                r_read_direction;
    logic                r_error;
    logic                r_write_ready;
    logic                r_read_ready;

    // transfer state
    t_status             r_status,   n_status;
    logic                r_armed,    n_armed;
    logic                r_in_addr,  n_in_addr;
    logic [POS_W-1:0]    r_position, n_position;
    logic [TGT_W-1:0]    r_held_target, n_held_target;
    logic [POS_W-1:0]    r_held_rlen,   n_held_rlen;
    logic [POS_W-1:0]    r_held_plen,   n_held_plen;
    logic                r_held_read,   n_held_read;

    logic [BYTE_W-1:0]   r_reg_bytes [REGISTER_BYTES_MAX];
    logic [BYTE_W-1:0]   r_pay_bytes [PAYLOAD_BYTES_MAX];

    // result register
    logic                r_out_valid;
    t_action             r_out_action,  n_action;
    logic [BYTE_W-1:0]   r_out_addr,    n_addr;
    logic                r_out_quick,   n_quick;
    logic [BYTE_W-1:0]   r_out_send,    n_send;
    logic                r_out_svalid,  n_svalid;
    logic [IDX_W-1:0]    r_out_sidx,    n_sidx;
    logic [BYTE_W-1:0]   r_out_sbyte,   n_sbyte;
    logic                r_out_done,    n_done;

    logic                advance;
    logic                reg_we;
    logic                pay_we;
    logic [PIDX_W-1:0]   pay_waddr;
    logic [BYTE_W-1:0]   pay_wdata;

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (o_in_ready && i_in_valid) begin
            r_cmd             <= t_cmd'(i_cmd);
            r_byte_index      <= i_byte_index;
            r_byte_value      <= i_byte_value;
            r_target_address  <= i_target_address;
            r_register_length <= i_register_length;
            r_payload_length  <= i_payload_length;
            r_read_direction  <= i_read_direction;
            r_error           <= i_arbitration_lost | i_bus_fault | i_got_nack;
            r_write_ready     <= i_write_ready;
            r_read_ready      <= i_read_ready;
        end
    end

    always_comb begin
        logic             v_restart;
        logic             v_in_addr;
        logic [POS_W-1:0] v_pos;
        int               v_rlen;
        int               v_plen;

        v_restart     = 1'b0;
        v_in_addr     = r_in_addr;
        v_pos         = r_position;
        v_rlen        = 32'(r_register_length);
        v_plen        = 32'(r_payload_length);

        n_status      = r_status;
        n_armed       = r_armed;
        n_in_addr     = r_in_addr;
        n_position    = r_position;
        n_held_target = r_held_target;
        n_held_rlen   = r_held_rlen;
        n_held_plen   = r_held_plen;
        n_held_read   = r_held_read;

        n_action = ACT_NONE;
        n_addr   = '0;
        n_quick  = 1'b0;
        n_send   = '0;
        n_svalid = 1'b0;
        n_sidx   = '0;
        n_sbyte  = '0;
        n_done   = 1'b0;

        reg_we    = 1'b0;
        pay_we    = 1'b0;
        pay_waddr = PIDX_W'(r_byte_index);
        pay_wdata = r_byte_value;

        if (advance) begin
            unique case (r_cmd)
                CMD_LOAD_REG: begin
                    reg_we = (32'(r_byte_index) < REGISTER_BYTES_MAX);
                end
                CMD_LOAD_DATA: begin
                    pay_we = (32'(r_byte_index) < PAYLOAD_BYTES_MAX);
                end
                CMD_START: begin
                    if (r_status != ST_BUSY) begin
                        if (v_rlen > REGISTER_BYTES_MAX) v_rlen = REGISTER_BYTES_MAX;
                        if (v_plen > PAYLOAD_BYTES_MAX)  v_plen = PAYLOAD_BYTES_MAX;
                        n_held_target = r_target_address;
                        n_held_rlen   = POS_W'(v_rlen);
                        n_held_plen   = POS_W'(v_plen);
                        n_held_read   = r_read_direction;
                        n_armed       = 1'b1;
                        n_position    = '0;
                        n_status      = ST_BUSY;
                        n_quick       = (r_register_length == '0) && (r_payload_length == '0);
                        n_in_addr     = (r_register_length != '0);
                        // read bit only when no register address precedes the data
                        n_addr        = {r_target_address,
                                         (r_register_length == '0) && r_read_direction};
                        n_action      = ACT_ADDR;
                    end
                end
                CMD_EVENT: begin
                    if (r_armed) begin
                        if (r_error) begin
                            n_action = ACT_STOP_NACK;
                            n_status = ST_FAILED;
                            n_done   = 1'b1;
                        end else if (r_write_ready) begin
                            if (v_in_addr) begin
                                if (v_pos < r_held_rlen) begin
                                    n_action = ACT_SEND;
                                    n_send   = r_reg_bytes[RIDX_W'(v_pos)];
                                    v_pos    = v_pos + POS_W'(1);
                                end else begin
                                    v_in_addr = 1'b0;
                                    v_pos     = '0;
                                    if (r_held_read) begin
                                        n_action  = ACT_RESTART_RD;
                                        n_addr    = {r_held_target, READ_BIT};
                                        v_restart = 1'b1;
                                    end
                                end
                            end
                            // register-address stage done or never entered, and no restart: fall into the data phase
                            if (!v_restart && !v_in_addr) begin
                                if (v_pos < r_held_plen) begin
                                    n_action = ACT_SEND;
                                    n_send   = r_pay_bytes[PIDX_W'(v_pos)];
                                    v_pos    = v_pos + POS_W'(1);
                                end else begin
                                    n_action = ACT_STOP_ACK;
                                    n_status = ST_IDLE;
                                    n_done   = 1'b1;
                                end
                            end
                            n_in_addr  = v_in_addr;
                            n_position = v_pos;
                        end else if (r_read_ready) begin
                            if (v_pos < r_held_plen) begin
                                pay_we    = 1'b1;
                                pay_waddr = PIDX_W'(v_pos);
                                pay_wdata = r_byte_value;
                                n_svalid  = 1'b1;
                                n_sidx    = IDX_W'(v_pos);
                                n_sbyte   = r_byte_value;
                                v_pos     = v_pos + POS_W'(1);
                            end
                            if (v_pos < r_held_plen) begin
                                n_action = ACT_RECV;
                            end else begin
                                n_action = ACT_STOP_NACK;
                                n_status = ST_IDLE;
                                n_done   = 1'b1;
                            end
                            n_position = v_pos;
                        end
                    end
                end
                default: begin
                    n_action = ACT_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status      <= ST_IDLE;
            r_armed       <= 1'b0;
            r_in_addr     <= 1'b0;
            r_position    <= '0;
            r_held_target <= '0;
            r_held_rlen   <= '0;
            r_held_plen   <= '0;
            r_held_read   <= 1'b0;
        end else begin
            r_status      <= n_status;
            r_armed       <= n_armed;
            r_in_addr     <= n_in_addr;
            r_position    <= n_position;
            r_held_target <= n_held_target;
            r_held_rlen   <= n_held_rlen;
            r_held_plen   <= n_held_plen;
            r_held_read   <= n_held_read;
        end
    end

    always_ff @(posedge i_clk) begin
        if (reg_we) begin
            r_reg_bytes[RIDX_W'(r_byte_index)] <= r_byte_value;
        end
        if (pay_we) begin
            r_pay_bytes[pay_waddr] <= pay_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
        if (advance) begin
            r_out_action <= n_action;
            r_out_addr   <= n_addr;
            r_out_quick  <= n_quick;
            r_out_send   <= n_send;
            r_out_svalid <= n_svalid;
            r_out_sidx   <= n_sidx;
            r_out_sbyte  <= n_sbyte;
            r_out_done   <= n_done;
        end
    end

    // status after the step travels with its result
    logic [STATUS_W-1:0] r_out_status;
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_status <= n_status;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_action         = r_out_action;
    assign o_address_byte   = r_out_addr;
    assign o_quick_command  = r_out_quick;
    assign o_send_byte      = r_out_send;
    assign o_stored_valid   = r_out_svalid;
    assign o_stored_index   = r_out_sidx;
    assign o_stored_byte    = r_out_sbyte;
    assign o_transfer_state = r_out_status;
    assign o_completed      = r_out_done;

`ifndef SYNTHESIS
    a_done_is_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_done) |->
            (r_out_action == ACT_STOP_ACK || r_out_action == ACT_STOP_NACK))
        else $error("completion without a stop action");

    a_store_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_svalid) |->
            (r_out_action == ACT_RECV || r_out_action == ACT_STOP_NACK))
        else $error("byte stored outside a read step");

    a_addr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_action == ACT_ADDR) |-> (r_out_status == ST_BUSY))
        else $error("address issued but transfer not busy");

    a_addr_stage_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_addr |-> (r_held_rlen != '0))
        else $error("address stage with no register bytes");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_armed |-> (32'(r_position) <= LEN_MAX))
        else $error("position past buffer size");
`endif

endmodule
`default_nettype wire
